// ===== rtl/ttl_pkg.sv =====
`default_nettype none
package ttl_pkg;

   // field widths
   localparam int CODE_WIDTH      = 8;
   localparam int TEMP_WIDTH      = 7;
   localparam int LEVEL_WIDTH     = 2;
   localparam int LIMIT_WIDTH     = 7;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int LIMIT_COUNT     = 6;
   localparam int REQ_DATA_WIDTH  = 8;
   localparam int REQ_USER_WIDTH  = 2;
   localparam int RSP_DATA_WIDTH  = 16;

   // temperature range and hysteresis in degrees
   localparam int TABLE_LEN = 80;
   localparam int TEMP_BASE = 31;
   localparam int TEMP_OVER = 110;
   localparam int DEBOUNCE  = 2;

   // threshold register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OFF_LIMIT_ONE   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OFF_LIMIT_TWO   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OFF_LIMIT_THREE = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ON_LIMIT_ONE    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ON_LIMIT_TWO    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ON_LIMIT_THREE  = 3'd5;

   // threshold reset values
   localparam logic [LIMIT_WIDTH-1:0] OFF_LIMIT_ONE_RST   = 7'd50;
   localparam logic [LIMIT_WIDTH-1:0] OFF_LIMIT_TWO_RST   = 7'd55;
   localparam logic [LIMIT_WIDTH-1:0] OFF_LIMIT_THREE_RST = 7'd60;
   localparam logic [LIMIT_WIDTH-1:0] ON_LIMIT_ONE_RST    = 7'd45;
   localparam logic [LIMIT_WIDTH-1:0] ON_LIMIT_TWO_RST    = 7'd55;
   localparam logic [LIMIT_WIDTH-1:0] ON_LIMIT_THREE_RST  = 7'd60;

   // descending converter codes, entry i is TEMP_BASE + i degrees
   localparam logic [CODE_WIDTH-1:0] CODE_TABLE [0:TABLE_LEN-1] = '{
      8'hff,8'hff,8'hfb,8'hf4,8'hee,8'he7,8'he1,8'hdb,8'hd4,8'hce,8'hc9,8'hc3,8'hbd,8'hb8,
      8'hb2,8'had,8'ha8,8'ha3,8'h9e,8'h99,8'h94,8'h90,8'h8c,8'h87,8'h83,8'h7f,8'h7b,8'h77,
      8'h74,8'h70,8'h6d,8'h69,8'h66,8'h63,8'h60,8'h5d,8'h5a,8'h57,8'h54,8'h52,8'h4f,8'h4d,
      8'h4a,8'h48,8'h46,8'h44,8'h42,8'h40,8'h3e,8'h3c,8'h3a,8'h38,8'h37,8'h35,8'h33,8'h32,
      8'h30,8'h2f,8'h2d,8'h2c,8'h2b,8'h29,8'h28,8'h27,8'h26,8'h25,8'h24,8'h23,8'h22,8'h21,
      8'h20,8'h1f,8'h1e,8'h1d,8'h1c,8'h1b,8'h1b,8'h1a,8'h19,8'h18
   };

   typedef logic [(1 << CODE_WIDTH)-1:0][TEMP_WIDTH-1:0] temp_lut_type;

   // code to degrees for every code: nearest entry, tie to lower index,
   // codes below the last entry read as the top temperature
   function automatic temp_lut_type build_temp_lut();
      temp_lut_type lut;
      int           c;
      int           i;
      int           idx;
      int           hi;
      int           lo;
      int           deg;
      logic         found;
      for (c = 0; c < (1 << CODE_WIDTH); c++) begin
         found = 1'b0;
         idx   = 0;
         for (i = 0; i < TABLE_LEN - 1; i++) begin
            if (!found && int'(CODE_TABLE[i]) >= c && int'(CODE_TABLE[i+1]) <= c) begin
               found = 1'b1;
               idx   = i;
            end
         end
         hi = int'(CODE_TABLE[idx]);
         lo = int'(CODE_TABLE[idx+1]);
         if (c < int'(CODE_TABLE[TABLE_LEN-1])) deg = TEMP_OVER;
         else if (!found) deg = TEMP_BASE;
         else if (c == hi) deg = TEMP_BASE + idx;
         else if (c == lo) deg = TEMP_BASE + idx + 1;
         else if (hi == lo) deg = TEMP_BASE + idx;
         else if (2 * c >= hi + lo) deg = TEMP_BASE + idx;
         else deg = TEMP_BASE + idx + 1;
         lut[c] = TEMP_WIDTH'(deg);
      end
      return lut;
   endfunction

   localparam temp_lut_type TEMP_LUT = build_temp_lut();

endpackage
`default_nettype wire

// ===== rtl/thermistor_thermal_level.sv =====
// Path: input register, lookup and level judge, result register; a request
// waits in the input register while the result register is stalled.
// Throughput: one request per cycle unless the result side stalls; the stored
// level loop closes through the level register. Reset (synchronous, active high)
// empties both registers, clears the stored level to 0 and loads the default thresholds.
`default_nettype none
module thermistor_thermal_level (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [ttl_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,  // [7:0] adc_code
   input  wire logic [ttl_pkg::REQ_USER_WIDTH-1:0]   req_tuser,  // [0] panel select, [1] clear
   // result channel
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [ttl_pkg::RSP_DATA_WIDTH-1:0]        rsp_tdata,  // [6:0] temperature,
                                                                 // [8:7] level, zero above
   // threshold registers
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [ttl_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [ttl_pkg::LIMIT_WIDTH-1:0]      csr_data
);

   localparam int TW = ttl_pkg::TEMP_WIDTH;
   localparam int LW = ttl_pkg::LEVEL_WIDTH;
   localparam int MW = ttl_pkg::LIMIT_WIDTH;

   logic                              in_valid_ff, in_valid_in;
   logic [ttl_pkg::CODE_WIDTH-1:0]    in_code_ff, in_code_in;
   logic                              in_panel_ff, in_panel_in;
   logic                              in_clear_ff, in_clear_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [TW-1:0]                     rsp_temp_ff, rsp_temp_in;
   logic [LW-1:0]                     level_ff, level_in;
   logic [MW-1:0]                     limit_ff [ttl_pkg::LIMIT_COUNT];
   logic [MW-1:0]                     limit_in [ttl_pkg::LIMIT_COUNT];

   logic                              req_take;
   logic                              advance;
   logic [TW-1:0]                     temp;
   logic [MW:0]                       temp_x, lim1_x, lim2_x, lim3_x;
   logic [MW:0]                       temp_up;
   logic [LW-1:0]                     raw_level, fall_level, rise_level;

   // handshake: the result register frees the input register
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // input register
   always_comb begin
      in_valid_in = req_take || (in_valid_ff && !advance);
      in_code_in  = in_code_ff;
      in_panel_in = in_panel_ff;
      in_clear_in = in_clear_ff;
      if (req_take) begin
         in_code_in  = req_tdata[ttl_pkg::CODE_WIDTH-1:0];
         in_panel_in = req_tuser[0];
         in_clear_in = req_tuser[1];
      end
   end

   // code to degrees, then thresholds of the selected panel mode
   always_comb begin
      temp    = ttl_pkg::TEMP_LUT[in_code_ff];
      temp_x  = {1'b0, temp};
      temp_up = temp_x + (MW+1)'(ttl_pkg::DEBOUNCE);
      lim1_x  = {1'b0, in_panel_ff ? limit_ff[3] : limit_ff[0]};
      lim2_x  = {1'b0, in_panel_ff ? limit_ff[4] : limit_ff[1]};
      lim3_x  = {1'b0, in_panel_ff ? limit_ff[5] : limit_ff[2]};
   end

   // level judge: plain compare, hold on a small fall, then hold on a small rise
   always_comb begin
      if (temp_x < lim1_x) raw_level = 2'd0;
      else if (temp_x < lim2_x) raw_level = 2'd1;
      else if (temp_x < lim3_x) raw_level = 2'd2;
      else raw_level = 2'd3;

      fall_level = raw_level;
      if (raw_level == 2'd0 && level_ff == 2'd1) begin
         if (temp_up > lim1_x) fall_level = 2'd1;
      end else if (raw_level == 2'd1 && level_ff == 2'd2) begin
         if (temp_up > lim2_x) fall_level = 2'd2;
      end else if (raw_level == 2'd2 && level_ff == 2'd3) begin
         if (temp_up > lim3_x) fall_level = 2'd3;
      end

      // t < limit + 2; the extra top bit keeps limit + 2 from wrapping
      rise_level = fall_level;
      if (fall_level == 2'd3 && level_ff == 2'd2) begin
         if (temp_x < lim3_x + (MW+1)'(ttl_pkg::DEBOUNCE)) rise_level = 2'd2;
      end else if (fall_level == 2'd2 && level_ff == 2'd1) begin
         if (temp_x < lim2_x + (MW+1)'(ttl_pkg::DEBOUNCE)) rise_level = 2'd1;
      end else if (fall_level == 2'd1 && level_ff == 2'd0) begin
         if (temp_x < lim1_x + (MW+1)'(ttl_pkg::DEBOUNCE)) rise_level = 2'd0;
      end
   end

   // result register and stored level
   always_comb begin
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);
      rsp_temp_in  = advance ? temp : rsp_temp_ff;
      level_in     = level_ff;
      if (advance) begin
         level_in = in_clear_ff ? 2'd0 : rise_level;
      end
   end

   // threshold writes, unknown indexes ignored
   always_comb begin
      for (int k = 0; k < ttl_pkg::LIMIT_COUNT; k++) begin
         limit_in[k] = limit_ff[k];
      end
      if (csr_valid && csr_ready) begin
         case (csr_index)
            ttl_pkg::CSR_OFF_LIMIT_ONE:   limit_in[0] = csr_data;
            ttl_pkg::CSR_OFF_LIMIT_TWO:   limit_in[1] = csr_data;
            ttl_pkg::CSR_OFF_LIMIT_THREE: limit_in[2] = csr_data;
            ttl_pkg::CSR_ON_LIMIT_ONE:    limit_in[3] = csr_data;
            ttl_pkg::CSR_ON_LIMIT_TWO:    limit_in[4] = csr_data;
            ttl_pkg::CSR_ON_LIMIT_THREE:  limit_in[5] = csr_data;
            default: ;
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         level_ff     <= '0;
         limit_ff[0]  <= ttl_pkg::OFF_LIMIT_ONE_RST;
         limit_ff[1]  <= ttl_pkg::OFF_LIMIT_TWO_RST;
         limit_ff[2]  <= ttl_pkg::OFF_LIMIT_THREE_RST;
         limit_ff[3]  <= ttl_pkg::ON_LIMIT_ONE_RST;
         limit_ff[4]  <= ttl_pkg::ON_LIMIT_TWO_RST;
         limit_ff[5]  <= ttl_pkg::ON_LIMIT_THREE_RST;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         level_ff     <= level_in;
         limit_ff     <= limit_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_code_ff  <= in_code_in;
      in_panel_ff <= in_panel_in;
      in_clear_ff <= in_clear_in;
      rsp_temp_ff <= rsp_temp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(ttl_pkg::RSP_DATA_WIDTH-TW-LW)'(0), level_ff, rsp_temp_ff};

   // a cleared request leaves level 0 behind
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      advance && in_clear_ff |=> level_ff == 2'd0)
      else $error("level not cleared");

   // the stored level only moves when a result is loaded
   a_level_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(level_ff))
      else $error("level changed without a result");

   // reported temperature stays within the table range
   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_temp_ff >= TW'(ttl_pkg::TEMP_BASE)
                    && rsp_temp_ff <= TW'(ttl_pkg::TEMP_OVER))
      else $error("temperature out of range");

   // input register never drops a request while the result side stalls
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_code_ff))
      else $error("pending request lost");

endmodule
`default_nettype wire

// ===== sim/thermal_level_checker.sv =====
`timescale 1ns / 100ps
module thermal_level_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   input  logic [ttl_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,   // [7:0] adc_code
   input  logic [ttl_pkg::REQ_USER_WIDTH-1:0]   req_tuser,   // [0] panel select, [1] clear
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic [ttl_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,   // [6:0] temperature,
                                                             // [8:7] level
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [ttl_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [ttl_pkg::LIMIT_WIDTH-1:0]      csr_data,
   output int                                   failures,
   output int                                   outstanding,
   output int                                   readings_checked
);
   import ttl_pkg::*;

   typedef struct packed {
      logic [TEMP_WIDTH-1:0]  temperature;
      logic [LEVEL_WIDTH-1:0] level;
   } reading_type;

   reading_type            expected_readings [$];
   logic [LIMIT_WIDTH-1:0] limit_regs [LIMIT_COUNT];
   logic [LEVEL_WIDTH-1:0] level_model;
   int                     fail_count    = 0;
   int                     checked_count = 0;

   // nearest table entry, ties to the lower index, codes under the table read hot
   function automatic logic [TEMP_WIDTH-1:0] degrees_of(input logic [CODE_WIDTH-1:0] code);
      int idx;
      int dist_hi;
      int dist_lo;
      if (code < CODE_TABLE[TABLE_LEN-1])
         return TEMP_WIDTH'(TEMP_OVER);
      idx = 0;
      while (idx < TABLE_LEN - 2 &&
             !(CODE_TABLE[idx] >= code && CODE_TABLE[idx+1] <= code))
         idx++;
      dist_hi = int'(CODE_TABLE[idx]) - int'(code);
      dist_lo = int'(code) - int'(CODE_TABLE[idx+1]);
      return TEMP_WIDTH'(TEMP_BASE + ((dist_hi <= dist_lo) ? idx : idx + 1));
   endfunction

   // raw band from the thresholds, then hold falls and rises by the debounce margin
   function automatic logic [LEVEL_WIDTH-1:0] next_level(input int t, input int lim_a,
                                                         input int lim_b, input int lim_c,
                                                         input logic [LEVEL_WIDTH-1:0] prev);
      int band;
      if (t < lim_a) band = 0;
      else if (t < lim_b) band = 1;
      else if (t < lim_c) band = 2;
      else band = 3;

      if (band == 0 && prev == 1) begin
         if (t > lim_a - DEBOUNCE) band = 1;
      end else if (band == 1 && prev == 2) begin
         if (t > lim_b - DEBOUNCE) band = 2;
      end else if (band == 2 && prev == 3) begin
         if (t > lim_c - DEBOUNCE) band = 3;
      end

      if (band == 3 && prev == 2) begin
         if (t < lim_c + DEBOUNCE) band = 2;
      end else if (band == 2 && prev == 1) begin
         if (t < lim_b + DEBOUNCE) band = 1;
      end else if (band == 1 && prev == 0) begin
         if (t < lim_a + DEBOUNCE) band = 0;
      end
      return LEVEL_WIDTH'(band);
   endfunction

   task automatic flag_mismatch(input string what, input int want, input int got);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
   endtask

   always @(posedge clock) begin : watch_bus
      reading_type                  want;
      logic [TEMP_WIDTH-1:0]        temp;
      logic [CSR_INDEX_WIDTH-1:0]   base;
      if (reset) begin
         expected_readings.delete();
         limit_regs[CSR_OFF_LIMIT_ONE]   = OFF_LIMIT_ONE_RST;
         limit_regs[CSR_OFF_LIMIT_TWO]   = OFF_LIMIT_TWO_RST;
         limit_regs[CSR_OFF_LIMIT_THREE] = OFF_LIMIT_THREE_RST;
         limit_regs[CSR_ON_LIMIT_ONE]    = ON_LIMIT_ONE_RST;
         limit_regs[CSR_ON_LIMIT_TWO]    = ON_LIMIT_TWO_RST;
         limit_regs[CSR_ON_LIMIT_THREE]  = ON_LIMIT_THREE_RST;
         level_model = '0;
      end else begin
         // threshold writes; indexes past the last register are dropped
         if (csr_valid && csr_ready && csr_index < LIMIT_COUNT)
            limit_regs[csr_index] = csr_data;

         // compare a result with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            checked_count++;
            if (expected_readings.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t unexpected result 0x%04h", $realtime, rsp_tdata);
            end else begin
               want = expected_readings.pop_front();
               if (rsp_tdata[6:0] !== want.temperature)
                  flag_mismatch("temperature", int'(want.temperature),
                                int'(rsp_tdata[6:0]));
               if (rsp_tdata[8:7] !== want.level)
                  flag_mismatch("level", int'(want.level), int'(rsp_tdata[8:7]));
               if (rsp_tdata[15:9] !== '0)
                  flag_mismatch("spare bits", 0, int'(rsp_tdata[15:9]));
            end
         end

         // predict the result of an accepted request
         if (req_tvalid && req_tready) begin
            temp = degrees_of(req_tdata[7:0]);
            base = req_tuser[0] ? CSR_ON_LIMIT_ONE : CSR_OFF_LIMIT_ONE;
            if (req_tuser[1])
               level_model = '0;
            else
               level_model = next_level(int'(temp), int'(limit_regs[base]),
                                        int'(limit_regs[base + 3'd1]),
                                        int'(limit_regs[base + 3'd2]),
                                        level_model);
            want.temperature = temp;
            want.level       = level_model;
            expected_readings.push_back(want);
         end
      end
      outstanding      <= expected_readings.size();
      failures         <= fail_count;
      readings_checked <= checked_count;
   end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
   import ttl_pkg::*;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_SIX   = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_SEVEN = 3'd7;
   localparam int PHASE_COUNT      = 7;
   localparam int ITEMS_PER_PHASE  = 165;

   typedef struct packed {
      logic [LIMIT_WIDTH-1:0] off_one;
      logic [LIMIT_WIDTH-1:0] off_two;
      logic [LIMIT_WIDTH-1:0] off_three;
      logic [LIMIT_WIDTH-1:0] on_one;
      logic [LIMIT_WIDTH-1:0] on_two;
      logic [LIMIT_WIDTH-1:0] on_three;
   } limit_set_type;

   logic                        clock      = 1'b0;
   logic                        reset      = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [REQ_DATA_WIDTH-1:0]   req_tdata  = '0;
   logic [REQ_USER_WIDTH-1:0]   req_tuser  = '0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0]   rsp_tdata;
   logic                        csr_valid  = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index  = '0;
   logic [LIMIT_WIDTH-1:0]      csr_data   = '0;

   int failures;
   int outstanding;
   int readings_checked;
   int requests_sent = 0;
   int walk_code     = 128;

   always #5 clock = ~clock;

   thermistor_thermal_level u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   thermal_level_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .failures         (failures),
      .outstanding      (outstanding),
      .readings_checked (readings_checked)
   );

   // mostly short gaps, now and then a long one
   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [CODE_WIDTH-1:0] code_for(input int degrees);
      return CODE_TABLE[degrees - TEMP_BASE];
   endfunction

   // result side back-pressure: ready runs broken by stalls
   initial begin
      int stall;
      int run;
      @(posedge clock);
      forever begin
         stall = pick_idle();
         run   = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                             : $urandom_range(1, 20);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat (run) @(posedge clock);
      end
   end

   // one request; tvalid stays high on return
   task automatic send_request(input logic [CODE_WIDTH-1:0] code, input logic panel,
                               input logic clear, input bit no_gap);
      int gap;
      gap = no_gap ? 0 : pick_idle();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= code;
      req_tuser  <= {clear, panel};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
   endtask

   // one register write; csr_valid stays high on return
   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [LIMIT_WIDTH-1:0] value);
      int gap;
      gap = pick_idle();
      if (gap > 0) begin
         csr_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic program_limits(input limit_set_type s);
      write_csr(CSR_OFF_LIMIT_ONE, s.off_one);
      write_csr(CSR_OFF_LIMIT_TWO, s.off_two);
      write_csr(CSR_OFF_LIMIT_THREE, s.off_three);
      write_csr(CSR_ON_LIMIT_ONE, s.on_one);
      write_csr(CSR_ON_LIMIT_TWO, s.on_two);
      write_csr(CSR_ON_LIMIT_THREE, s.on_three);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // let every predicted result come back, then idle with tvalid low
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   function automatic limit_set_type ordered_set(input int max_step);
      limit_set_type s;
      int            a;
      a = $urandom_range(35, 85);
      s.off_one   = LIMIT_WIDTH'(a);
      s.off_two   = LIMIT_WIDTH'(a + $urandom_range(0, max_step));
      s.off_three = LIMIT_WIDTH'(int'(s.off_two) + $urandom_range(0, max_step));
      a = $urandom_range(35, 85);
      s.on_one    = LIMIT_WIDTH'(a);
      s.on_two    = LIMIT_WIDTH'(a + $urandom_range(0, max_step));
      s.on_three  = LIMIT_WIDTH'(int'(s.on_two) + $urandom_range(0, max_step));
      return s;
   endfunction

   function automatic limit_set_type settings_for(input int phase);
      limit_set_type s;
      case (phase)
         0: s = '{LIMIT_WIDTH'($urandom_range(0, 127)), LIMIT_WIDTH'($urandom_range(0, 127)),
                  LIMIT_WIDTH'($urandom_range(0, 127)), LIMIT_WIDTH'($urandom_range(0, 127)),
                  LIMIT_WIDTH'($urandom_range(0, 127)), LIMIT_WIDTH'($urandom_range(0, 127))};
         1: s = ordered_set(10);
         2: s = '0;
         3: s = '1;
         4: s = '{7'd0, 7'd127, 7'd0, 7'd127, 7'd0, 7'd127};
         5: s = ordered_set(3);
         default: s = ordered_set(8);
      endcase
      return s;
   endfunction

   // random requests: mostly a slow drift of the code, some jumps and
   // threshold-hugging temperatures, occasional clears and panel flips
   task automatic run_random(input int count, input limit_set_type s);
      int   n;
      int   r;
      int   deg;
      int   lim;
      logic panel;
      logic clear;
      logic [CODE_WIDTH-1:0] code;
      panel = 1'($urandom_range(0, 1));
      for (n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 4) panel = ~panel;
         clear = ($urandom_range(0, 99) < 4);
         r = $urandom_range(0, 99);
         if (r < 70) begin
            walk_code = walk_code + $urandom_range(0, 6) - 3;
            if (walk_code < 0) walk_code = 0;
            if (walk_code > 255) walk_code = 255;
            code = CODE_WIDTH'(walk_code);
         end else if (r < 85) begin
            code = CODE_WIDTH'($urandom_range(0, 255));
            walk_code = int'(code);
         end else begin
            case ($urandom_range(0, 2))
               0: lim = int'(panel ? s.on_one : s.off_one);
               1: lim = int'(panel ? s.on_two : s.off_two);
               default: lim = int'(panel ? s.on_three : s.off_three);
            endcase
            deg = lim + $urandom_range(0, 6) - 3;
            if (deg < TEMP_BASE) deg = TEMP_BASE;
            if (deg > TEMP_OVER) deg = TEMP_OVER;
            code = code_for(deg);
            walk_code = int'(code);
         end
         send_request(code, panel, clear, (n % 60) < 15);
      end
   endtask

   initial begin
      int            phase;
      limit_set_type s;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // writes past the last register must leave the defaults alone
      write_csr(CSR_UNUSED_SIX, '0);
      write_csr(CSR_UNUSED_SEVEN, '0);
      csr_valid <= 1'b0;
      @(posedge clock);

      // directed: table ends, rounding, clears, level steps, holds on falls from 3 and 2 and on rises to 1 and 2
      send_request(8'hff, 1'b0, 1'b0, 1'b0);
      send_request(8'h00, 1'b0, 1'b0, 1'b0);
      send_request(8'h17, 1'b0, 1'b0, 1'b0);
      send_request(8'h18, 1'b0, 1'b0, 1'b0);
      send_request(code_for(59), 1'b0, 1'b0, 1'b0);
      send_request(code_for(58), 1'b0, 1'b0, 1'b0);
      send_request(code_for(56), 1'b0, 1'b0, 1'b0);
      send_request(code_for(54), 1'b0, 1'b0, 1'b0);
      send_request(code_for(53), 1'b0, 1'b0, 1'b0);
      send_request(8'h00, 1'b0, 1'b1, 1'b0);
      send_request(code_for(51), 1'b0, 1'b0, 1'b0);
      send_request(code_for(52), 1'b0, 1'b0, 1'b0);
      send_request(code_for(55), 1'b0, 1'b0, 1'b0);
      send_request(code_for(57), 1'b0, 1'b0, 1'b0);
      send_request(code_for(44), 1'b1, 1'b0, 1'b0);
      send_request(8'hfd, 1'b1, 1'b0, 1'b0);
      send_request(8'hfc, 1'b1, 1'b0, 1'b0);
      send_request(8'hfe, 1'b1, 1'b0, 1'b0);
      send_request(8'h1a, 1'b1, 1'b0, 1'b0);
      send_request(8'h1b, 1'b1, 1'b0, 1'b0);
      send_request(8'h80, 1'b1, 1'b0, 1'b0);
      send_request(code_for(47), 1'b1, 1'b0, 1'b0);
      send_request(8'hff, 1'b1, 1'b1, 1'b0);
      send_request(code_for(50), 1'b0, 1'b0, 1'b0);
      drain();

      // random phases, each under its own threshold setting
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         s = settings_for(phase);
         program_limits(s);
         run_random(ITEMS_PER_PHASE, s);
         drain();
      end

      $display("covered %0d requests over %0d threshold settings plus defaults",
               requests_sent, PHASE_COUNT);
      $display("%0d results checked, %0d failures", readings_checked, failures);
      if (failures == 0 && outstanding == 0)
         $display("[thermistor_thermal_level] OK");
      else
         $display("[thermistor_thermal_level] ERROR");
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("timeout waiting for the block");
      $display("[thermistor_thermal_level] ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/ttl_pkg.sv
rtl/thermistor_thermal_level.sv
sim/thermal_level_checker.sv
sim/testbench.sv
